// ===== rtl/wtss_pkg.sv =====
// wtss_pkg: shared types and constants for the weekly time slot switch
// opcode codes, controller states, queued command and stored slot records
// no dependencies
package wtss_pkg;

	localparam int DAYS         = 7;
	localparam int QUEUE_DEPTH  = 2;
	localparam int OPC_W        = 2;
	localparam int DAY_W        = 3;
	localparam int IDX_W        = 4;
	localparam int HOUR_W       = 5;
	localparam int MIN_W        = 6;
	localparam int NOW_W        = 11;
	localparam int END_W        = 12;

	typedef enum logic [OPC_W-1:0] {
		OPC_SAVE = 2'd0,
		OPC_TICK = 2'd1,
		OPC_READ = 2'd2,
		OPC_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_RESULT
	} state_t;

	typedef struct packed {
		opcode_t             op;
		logic                day_ok;
		logic                slot_ok;
		logic [DAY_W-1:0]    day;
		logic [IDX_W-1:0]    slot_index;
		logic [HOUR_W-1:0]   hour;
		logic [MIN_W-1:0]    minute;
		logic [HOUR_W-1:0]   dur_hours;
		logic [MIN_W-1:0]    dur_minutes;
		logic [NOW_W-1:0]    now_min;
	} cmd_t;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MIN_W-1:0]    minute;
		logic [HOUR_W-1:0]   dur_hours;
		logic [MIN_W-1:0]    dur_minutes;
	} slot_t;

	// h*60 + m as h*64 - h*4 + m
	function automatic logic [NOW_W-1:0] to_minutes(input logic [HOUR_W-1:0] h,
			input logic [MIN_W-1:0] m);
		logic [NOW_W-1:0] h64;
		logic [NOW_W-1:0] h4;
		h64 = NOW_W'({h, 6'b0});
		h4  = NOW_W'({h, 2'b0});
		return h64 - h4 + NOW_W'(m);
	endfunction

endpackage

// ===== rtl/wtss_if.sv =====
// wtss_cmd_if and wtss_res_if: valid/ready channels of the weekly time slot switch
// carry one command item and one result item; no dependencies
interface wtss_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [2:0] day;
	logic [3:0] slot_index;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [4:0] dur_hours;
	logic [5:0] dur_minutes;

	modport source(output valid, opcode, day, slot_index, hour, minute, dur_hours,
		dur_minutes, input ready);
	modport sink(input valid, opcode, day, slot_index, hour, minute, dur_hours,
		dur_minutes, output ready);
endinterface

interface wtss_res_if;
	logic       valid;
	logic       ready;
	logic       relay_on;
	logic       slot_valid;
	logic [4:0] slot_hour;
	logic [5:0] slot_minute;
	logic [4:0] slot_dur_hours;
	logic [5:0] slot_dur_minutes;

	modport source(output valid, relay_on, slot_valid, slot_hour, slot_minute,
		slot_dur_hours, slot_dur_minutes, input ready);
	modport sink(input valid, relay_on, slot_valid, slot_hour, slot_minute,
		slot_dur_hours, slot_dur_minutes, output ready);
endinterface

// ===== rtl/wtss_front.sv =====
// wtss_front: accepts command items and classifies them for the queue
// depends on wtss_pkg and wtss_cmd_if
module wtss_front #(
	parameter int SLOTS_PER_DAY = 10
) (
	wtss_cmd_if.sink        cmd,
	output logic            q_valid,
	input  logic            q_ready,
	output wtss_pkg::cmd_t  q_data
);

	localparam logic [5:0] SLOTS_C = 6'(SLOTS_PER_DAY);

	assign q_valid   = cmd.valid;
	assign cmd.ready = q_ready;

	always_comb begin
		q_data             = '0;
		q_data.op          = wtss_pkg::opcode_t'(cmd.opcode);
		q_data.day_ok      = cmd.day < wtss_pkg::DAY_W'(wtss_pkg::DAYS);
		q_data.slot_ok     = {2'b0, cmd.slot_index} < SLOTS_C;
		q_data.day         = cmd.day;
		q_data.slot_index  = cmd.slot_index;
		q_data.hour        = cmd.hour;
		q_data.minute      = cmd.minute;
		q_data.dur_hours   = cmd.dur_hours;
		q_data.dur_minutes = cmd.dur_minutes;
		q_data.now_min     = wtss_pkg::to_minutes(cmd.hour, cmd.minute);
	end

endmodule

// ===== rtl/wtss_queue.sv =====
// wtss_queue: short command queue between front and back
// depends on wtss_pkg
module wtss_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wtss_pkg::cmd_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output wtss_pkg::cmd_t  out_data
);

	localparam int DEPTH = wtss_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wtss_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wtss_back.sv =====
// wtss_back: slot table memory, save/read execution, tick scan and result register
// depends on wtss_pkg and wtss_res_if
module wtss_back #(
	parameter int SLOTS_PER_DAY = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  wtss_pkg::cmd_t  q_data,
	wtss_res_if.source      res
);

	localparam int ENTRIES = wtss_pkg::DAYS * SLOTS_PER_DAY;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(SLOTS_PER_DAY + 1);

	wtss_pkg::state_t             state_q;
	wtss_pkg::state_t             state_d;
	wtss_pkg::cmd_t               cmd_q;
	logic [CNT_W-1:0]             scan_q;
	logic [ADDR_W-1:0]            base_q;
	logic                         hit_q;
	logic                         cmp_s1;
	logic                         relay_q;

	wtss_pkg::slot_t              ram [ENTRIES];
	logic [ENTRIES-1:0]           vld_q;
	wtss_pkg::slot_t              rdata_s1;
	logic                         rvld_s1;

	logic                         res_valid_q;
	logic                         res_relay_q;
	logic                         res_slot_valid_q;
	wtss_pkg::slot_t              res_slot_q;

	logic                         out_free;
	logic                         pop;
	logic                         addr_ok;
	logic [ADDR_W-1:0]            cmd_addr;
	logic [ADDR_W-1:0]            day_base;
	logic                         wr_en;
	logic                         rd_en;
	logic [ADDR_W-1:0]            rd_addr;
	logic                         load_now;
	logic                         load_result;
	logic [wtss_pkg::NOW_W-1:0]   start_min;
	logic [wtss_pkg::END_W-1:0]   end_min;
	logic                         hit;
	wtss_pkg::slot_t              wdata;

	assign out_free = !res_valid_q || res.ready;
	assign q_ready  = (state_q == wtss_pkg::ST_IDLE) && out_free;
	assign pop      = q_valid && q_ready;
	assign addr_ok  = q_data.day_ok && q_data.slot_ok;
	assign day_base = ADDR_W'(q_data.day) * ADDR_W'(SLOTS_PER_DAY);
	assign cmd_addr = day_base + ADDR_W'(q_data.slot_index);

	assign wdata.hour        = q_data.hour;
	assign wdata.minute      = q_data.minute;
	assign wdata.dur_hours   = q_data.dur_hours;
	assign wdata.dur_minutes = q_data.dur_minutes;

	assign start_min = wtss_pkg::to_minutes(rdata_s1.hour, rdata_s1.minute);
	assign end_min   = wtss_pkg::END_W'(start_min)
		+ wtss_pkg::END_W'(wtss_pkg::to_minutes(rdata_s1.dur_hours, rdata_s1.dur_minutes));
	assign hit       = rvld_s1 && (start_min <= cmd_q.now_min)
		&& (wtss_pkg::END_W'(cmd_q.now_min) <= end_min);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wtss_pkg::ST_IDLE: begin
				if (pop) begin
					if (q_data.op == wtss_pkg::OPC_TICK && q_data.day_ok) begin
						state_d = wtss_pkg::ST_SCAN;
					end else if (q_data.op == wtss_pkg::OPC_READ && addr_ok) begin
						state_d = wtss_pkg::ST_RESULT;
					end
				end
			end
			wtss_pkg::ST_SCAN: begin
				if (scan_q == CNT_W'(SLOTS_PER_DAY - 1)) begin
					state_d = wtss_pkg::ST_LAST;
				end
			end
			wtss_pkg::ST_LAST: begin
				state_d = wtss_pkg::ST_RESULT;
			end
			wtss_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = wtss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wtss_pkg::ST_IDLE;
			end
		endcase
	end

	// controls
	always_comb begin
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = cmd_addr;
		load_now    = 1'b0;
		load_result = 1'b0;
		case (state_q)
			wtss_pkg::ST_IDLE: begin
				if (pop) begin
					wr_en    = (q_data.op == wtss_pkg::OPC_SAVE) && addr_ok;
					rd_en    = (q_data.op == wtss_pkg::OPC_READ) && addr_ok;
					load_now = !((q_data.op == wtss_pkg::OPC_TICK && q_data.day_ok)
						|| (q_data.op == wtss_pkg::OPC_READ && addr_ok));
				end
			end
			wtss_pkg::ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = base_q + ADDR_W'(scan_q);
			end
			wtss_pkg::ST_LAST: begin
				rd_en = 1'b0;
			end
			wtss_pkg::ST_RESULT: begin
				load_result = out_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[cmd_addr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= ram[rd_addr];
		end
		if (pop) begin
			cmd_q  <= q_data;
			base_q <= day_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= wtss_pkg::ST_IDLE;
			vld_q            <= '0;
			rvld_s1          <= 1'b0;
			cmp_s1           <= 1'b0;
			scan_q           <= '0;
			hit_q            <= 1'b0;
			relay_q          <= 1'b0;
			res_valid_q      <= 1'b0;
			res_relay_q      <= 1'b0;
			res_slot_valid_q <= 1'b0;
			res_slot_q       <= '0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= (state_q == wtss_pkg::ST_SCAN);
			if (wr_en) begin
				vld_q[cmd_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
			if (pop) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else if (state_q == wtss_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmp_s1) begin
				hit_q <= hit_q | hit;
			end
			if (state_q == wtss_pkg::ST_LAST) begin
				relay_q <= hit_q | (cmp_s1 & hit);
			end
			if (load_now && q_data.op == wtss_pkg::OPC_TICK) begin
				relay_q <= 1'b0;
			end

			if (load_now) begin
				res_valid_q      <= 1'b1;
				res_relay_q      <= (q_data.op == wtss_pkg::OPC_TICK) ? 1'b0 : relay_q;
				res_slot_valid_q <= 1'b0;
				res_slot_q       <= '0;
			end else if (load_result) begin
				res_valid_q <= 1'b1;
				res_relay_q <= relay_q;
				if (cmd_q.op == wtss_pkg::OPC_READ && rvld_s1) begin
					res_slot_valid_q <= 1'b1;
					res_slot_q       <= rdata_s1;
				end else begin
					res_slot_valid_q <= 1'b0;
					res_slot_q       <= '0;
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid            = res_valid_q;
	assign res.relay_on         = res_relay_q;
	assign res.slot_valid       = res_slot_valid_q;
	assign res.slot_hour        = res_slot_q.hour;
	assign res.slot_minute      = res_slot_q.minute;
	assign res.slot_dur_hours   = res_slot_q.dur_hours;
	assign res.slot_dur_minutes = res_slot_q.dur_minutes;

endmodule

// ===== rtl/weekly_time_slot_switch.sv =====
// weekly_time_slot_switch: top level, front classifier, command queue and slot table back end
// from accept to result, save and ignored items pass the queue and result register; a read
// also the table read register; a tick the day scan, one table read per cycle, and ST_LAST
// save takes one item per cycle while results are taken; read and tick hold the back end busy
// reset: asynchronous, clears every slot valid bit, relay off, queue and result register empty
// depends on wtss_pkg, wtss_if, wtss_front, wtss_queue, wtss_back
module weekly_time_slot_switch #(
	parameter int SLOTS_PER_DAY = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	wtss_cmd_if.sink    cmd,
	wtss_res_if.source  res
);

	logic            fq_valid;
	logic            fq_ready;
	wtss_pkg::cmd_t  fq_data;
	logic            qb_valid;
	logic            qb_ready;
	wtss_pkg::cmd_t  qb_data;

	wtss_front #(
		.SLOTS_PER_DAY(SLOTS_PER_DAY)
	) u_front (
		.cmd     (cmd),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	wtss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	wtss_back #(
		.SLOTS_PER_DAY(SLOTS_PER_DAY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qb_valid),
		.q_ready (qb_ready),
		.q_data  (qb_data),
		.res     (res)
	);

endmodule

// ===== rtl/wtss_checker.sv =====
// wtss_checker: port level checks of the weekly time slot switch, bound to the top level
// depends on weekly_time_slot_switch ports only
module wtss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       relay_on,
	input logic       slot_valid,
	input logic [4:0] slot_hour,
	input logic [5:0] slot_minute,
	input logic [4:0] slot_dur_hours,
	input logic [5:0] slot_dur_minutes
);

	logic [2:0] pending_q;
	logic       cmd_acc;
	logic       res_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_acc && !res_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_acc && !cmd_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// stalled item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
		&& $stable({relay_on, slot_valid, slot_hour, slot_minute, slot_dur_hours,
			slot_dur_minutes}))
		else $error("result changed while stalled");

	// no slot data without a valid slot
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !slot_valid |-> slot_hour == '0 && slot_minute == '0
		&& slot_dur_hours == '0 && slot_dur_minutes == '0)
		else $error("slot fields set on a result without a valid slot");

	// every result answers an accepted item
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 3'd0)
		else $error("result with no item outstanding");

	// queue, back end and result register bound the items in flight
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many items in flight");

	// result register empty while in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind weekly_time_slot_switch wtss_checker u_wtss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.relay_on         (res.relay_on),
	.slot_valid       (res.slot_valid),
	.slot_hour        (res.slot_hour),
	.slot_minute      (res.slot_minute),
	.slot_dur_hours   (res.slot_dur_hours),
	.slot_dur_minutes (res.slot_dur_minutes)
);
